[src/sca_pkg.sv]
// ----------------------------------------------------------------------------
// sca_pkg
// Shared widths, opcodes and status codes for the stack calculator.
// ----------------------------------------------------------------------------
package sca_pkg;

	localparam int OPCODE_W    = 4;
	localparam int DATA_W      = 32;
	localparam int DEPTH_OUT_W = 5;
	localparam int STATUS_W    = 3;

	localparam int S_TDATA_W = 40;  // opcode + push_value, padded to whole bytes
	localparam int M_TDATA_W = 40;  // top_value + stack_depth + status

	localparam int DIV_STEPS  = 32; // one quotient bit per step
	localparam int SQRT_STEPS = 16; // one root bit per step
	localparam int ITER_W     = 5;

	localparam logic [OPCODE_W-1:0] OP_PUSH   = 4'd0;
	localparam logic [OPCODE_W-1:0] OP_ADD    = 4'd1;
	localparam logic [OPCODE_W-1:0] OP_SUB    = 4'd2;
	localparam logic [OPCODE_W-1:0] OP_MUL    = 4'd3;
	localparam logic [OPCODE_W-1:0] OP_DIV    = 4'd4;
	localparam logic [OPCODE_W-1:0] OP_SQUARE = 4'd5;
	localparam logic [OPCODE_W-1:0] OP_SQRT   = 4'd6;
	localparam logic [OPCODE_W-1:0] OP_LINEQ  = 4'd7;
	localparam logic [OPCODE_W-1:0] OP_RSUB   = 4'd8;
	localparam logic [OPCODE_W-1:0] OP_RDIV   = 4'd9;

	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OVER    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DIVZ    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NEGROOT = 3'd4;

endpackage

[src/sca_ram.sv]
// ----------------------------------------------------------------------------
// sca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[src/stack_calculator_alu.sv]
// ----------------------------------------------------------------------------
// stack_calculator_alu
// Integer RPN stack calculator with a bounded stack of signed 32-bit values.
// ----------------------------------------------------------------------------
// Path, input beat to result beat: DECODE, DONE for push, add, sub, rsub, mul, square,
//   unused codes, errors; div, rdiv, lineq add 32 ST_DIV steps, sqrt ST_SQRT, then ST_FIX.
// Throughput: one beat at a time; the next input beat is taken once the
//   shared divide/root unit is done and the result sits in the output register.
// Reset: arst_n clears the stack count, the sequencer and the output valid;
//   stack RAM contents are not cleared, entries are read only after a write.
// ----------------------------------------------------------------------------
module stack_calculator_alu #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input beats
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [sca_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [3:0] opcode, [35:4] push_value
	// result beats
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [sca_pkg::M_TDATA_W-1:0]  m_axis_tdata   // [31:0] top_value,
	                                                      // [36:32] stack_depth, [39:37] status
);

	localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,    // wait for an input beat
		ST_DECODE,  // second operand arrives from RAM; checks and ops without the shift-subtract unit
		ST_DIV,     // restoring division, one quotient bit per cycle
		ST_SQRT,    // digit-by-digit root, one root bit per cycle
		ST_FIX,     // sign fix of the quotient / root hand-off
		ST_DONE     // load output register
	} state_t;

	state_t                           state_q;
	logic [sca_pkg::OPCODE_W-1:0]     op_q;
	logic [sca_pkg::DATA_W-1:0]       pv_q;
	logic [sca_pkg::STATUS_W-1:0]     status_q;

	// Top of stack lives in a register; the RAM holds the entries below it.
	logic [sca_pkg::DATA_W-1:0]       top_q;
	logic [CNT_W-1:0]                 count_q;

	// Shared shift-subtract unit state
	logic [sca_pkg::DATA_W-1:0]       rem_q;
	logic [sca_pkg::DATA_W-1:0]       acc_q;   // dividend / radicand shift, quotient bits
	logic [sca_pkg::DATA_W-1:0]       den_q;   // divisor, or root being built
	logic                             neg_q;
	logic                             is_div_q;
	logic [sca_pkg::ITER_W-1:0]       iter_q;

	logic                             m_valid_q;
	logic [sca_pkg::M_TDATA_W-1:0]    m_data_q;

	logic                             in_beat;
	logic [CNT_W-1:0]                 sec_idx;
	logic [CNT_W-1:0]                 top_idx;
	logic                             ram_wr_en;
	logic [sca_pkg::DATA_W-1:0]       second;

	logic                             is_full;
	logic                             has_one;
	logic                             has_two;

	logic [sca_pkg::DATA_W-1:0]       mul_b;
	logic [sca_pkg::DATA_W-1:0]       product;
	logic [sca_pkg::DATA_W-1:0]       num;
	logic [sca_pkg::DATA_W-1:0]       den;
	logic [sca_pkg::DATA_W-1:0]       num_abs;
	logic [sca_pkg::DATA_W-1:0]       den_abs;

	logic [sca_pkg::DATA_W+1:0]       sub_a;
	logic [sca_pkg::DATA_W+1:0]       sub_b;
	logic [sca_pkg::DATA_W+1:0]       diff;
	logic                             ge;

	logic [CNT_W+sca_pkg::DEPTH_OUT_W-1:0] depth_ext;
	logic [sca_pkg::DATA_W-1:0]       top_out;

	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	assign sec_idx = count_q - CNT_W'(2);
	assign top_idx = count_q - CNT_W'(1);

	assign is_full = (count_q == CNT_W'(STACK_DEPTH));
	assign has_one = (count_q != '0);
	assign has_two = (count_q > CNT_W'(1));

	// A push spills the old top into the RAM
	assign ram_wr_en = (state_q == ST_DECODE) && (op_q == sca_pkg::OP_PUSH)
	                   && !is_full && has_one;

	sca_ram #(
		.WIDTH (sca_pkg::DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (top_idx[ADDR_W-1:0]),
		.wr_data (top_q),
		.rd_en   (in_beat),
		.rd_addr (sec_idx[ADDR_W-1:0]),
		.rd_data (second)
	);

	// Single multiplier, low 32 bits kept
	assign mul_b   = (op_q == sca_pkg::OP_SQUARE) ? top_q : second;
	assign product = top_q * mul_b;

	// Division operands by opcode
	always_comb begin
		case (op_q)
			sca_pkg::OP_LINEQ: begin
				num = '0 - top_q;
				den = second;
			end
			sca_pkg::OP_RDIV: begin
				num = second;
				den = top_q;
			end
			default: begin
				num = top_q;
				den = second;
			end
		endcase
	end

	assign num_abs = num[sca_pkg::DATA_W-1] ? ('0 - num) : num;
	assign den_abs = den[sca_pkg::DATA_W-1] ? ('0 - den) : den;

	// Shared subtractor: trial remainder for division and for the root
	always_comb begin
		if (state_q == ST_SQRT) begin
			sub_a = {rem_q, acc_q[sca_pkg::DATA_W-1 -: 2]};
			sub_b = {den_q, 2'b01};
		end else begin
			sub_a = {1'b0, rem_q, acc_q[sca_pkg::DATA_W-1]};
			sub_b = {2'b00, den_q};
		end
	end

	assign diff = sub_a - sub_b;
	assign ge   = !diff[sca_pkg::DATA_W+1];

	// stack_depth is the count masked to 5 bits
	assign depth_ext = {{sca_pkg::DEPTH_OUT_W{1'b0}}, count_q};
	assign top_out   = has_one ? top_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// drain the output register; ST_DONE handles its own refill
			if (m_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						op_q    <= s_axis_tdata[sca_pkg::OPCODE_W-1:0];
						pv_q    <= s_axis_tdata[sca_pkg::OPCODE_W +: sca_pkg::DATA_W];
						state_q <= ST_DECODE;
					end
				end

				ST_DECODE: begin
					rem_q <= '0;
					case (op_q)
						sca_pkg::OP_PUSH: begin
							state_q <= ST_DONE;
							if (is_full) begin
								status_q <= sca_pkg::ST_OVER;
							end else begin
								status_q <= sca_pkg::ST_OK;
								top_q    <= pv_q;
								count_q  <= count_q + CNT_W'(1);
							end
						end
						sca_pkg::OP_SQUARE: begin
							state_q <= ST_DONE;
							if (!has_one) begin
								status_q <= sca_pkg::ST_UNDER;
							end else begin
								status_q <= sca_pkg::ST_OK;
								top_q    <= product;
							end
						end
						sca_pkg::OP_SQRT: begin
							if (!has_one) begin
								status_q <= sca_pkg::ST_UNDER;
								state_q  <= ST_DONE;
							end else if (top_q[sca_pkg::DATA_W-1]) begin
								status_q <= sca_pkg::ST_NEGROOT;
								state_q  <= ST_DONE;
							end else begin
								status_q <= sca_pkg::ST_OK;
								acc_q    <= top_q;
								den_q    <= '0;
								is_div_q <= 1'b0;
								iter_q   <= sca_pkg::ITER_W'(sca_pkg::SQRT_STEPS - 1);
								state_q  <= ST_SQRT;
							end
						end
						sca_pkg::OP_ADD, sca_pkg::OP_SUB, sca_pkg::OP_RSUB,
						sca_pkg::OP_MUL: begin
							state_q <= ST_DONE;
							if (!has_two) begin
								status_q <= sca_pkg::ST_UNDER;
							end else begin
								status_q <= sca_pkg::ST_OK;
								count_q  <= count_q - CNT_W'(1);
								case (op_q)
									sca_pkg::OP_ADD:  top_q <= top_q + second;
									sca_pkg::OP_SUB:  top_q <= top_q - second;
									sca_pkg::OP_RSUB: top_q <= second - top_q;
									default:          top_q <= product;
								endcase
							end
						end
						sca_pkg::OP_DIV, sca_pkg::OP_LINEQ, sca_pkg::OP_RDIV: begin
							if (!has_two) begin
								status_q <= sca_pkg::ST_UNDER;
								state_q  <= ST_DONE;
							end else if (den == '0) begin
								status_q <= sca_pkg::ST_DIVZ;
								state_q  <= ST_DONE;
							end else begin
								status_q <= sca_pkg::ST_OK;
								acc_q    <= num_abs;
								den_q    <= den_abs;
								neg_q    <= num[sca_pkg::DATA_W-1] ^ den[sca_pkg::DATA_W-1];
								is_div_q <= 1'b1;
								iter_q   <= sca_pkg::ITER_W'(sca_pkg::DIV_STEPS - 1);
								state_q  <= ST_DIV;
							end
						end
						default: begin
							// unused codes: no change, status ok
							status_q <= sca_pkg::ST_OK;
							state_q  <= ST_DONE;
						end
					endcase
				end

				ST_DIV: begin
					if (ge) begin
						rem_q <= diff[sca_pkg::DATA_W-1:0];
					end else begin
						rem_q <= sub_a[sca_pkg::DATA_W-1:0];
					end
					acc_q  <= {acc_q[sca_pkg::DATA_W-2:0], ge};
					iter_q <= iter_q - sca_pkg::ITER_W'(1);
					if (iter_q == '0) begin
						state_q <= ST_FIX;
					end
				end

				ST_SQRT: begin
					if (ge) begin
						rem_q <= diff[sca_pkg::DATA_W-1:0];
					end else begin
						rem_q <= sub_a[sca_pkg::DATA_W-1:0];
					end
					acc_q  <= {acc_q[sca_pkg::DATA_W-3:0], 2'b00};
					den_q  <= {den_q[sca_pkg::DATA_W-2:0], ge};
					iter_q <= iter_q - sca_pkg::ITER_W'(1);
					if (iter_q == '0) begin
						state_q <= ST_FIX;
					end
				end

				ST_FIX: begin
					if (is_div_q) begin
						top_q   <= neg_q ? ('0 - acc_q) : acc_q;
						count_q <= count_q - CNT_W'(1);
					end else begin
						top_q <= den_q;
					end
					state_q <= ST_DONE;
				end

				ST_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_data_q  <= {status_q, depth_ext[sca_pkg::DEPTH_OUT_W-1:0], top_out};
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count above depth");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q == ST_DECODE))
		else $error("accepted beat not decoded");

	a_spill_push: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("RAM spill without count increment");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && m_valid_q && !m_axis_tready) |=> (state_q == ST_DONE))
		else $error("result overwrote a pending output");

	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && status_q == sca_pkg::ST_OVER) |-> is_full)
		else $error("overflow reported on a stack that is not full");
`endif

endmodule

[bench/tb_stack_calculator_alu.sv]
// ----------------------------------------------------------------------------
// tb_stack_calculator_alu
// Self-checking bench for the RPN stack calculator. Opcode beats go in on the
// input stream; a local stack model predicts every result beat, and each beat
// is checked field by field. The bench runs directed corner cases first, then
// random sequences under several sender/receiver idling mixes, with one long
// output hold-off.
// ----------------------------------------------------------------------------
module tb_stack_calculator_alu;

	localparam int STACK_SLOTS    = 16;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int PAD_W          = sca_pkg::S_TDATA_W - sca_pkg::OPCODE_W - sca_pkg::DATA_W;

	localparam logic [sca_pkg::OPCODE_W-1:0] OP_FIRST_UNUSED = 4'd10;
	localparam logic [sca_pkg::OPCODE_W-1:0] OP_LAST_UNUSED  = 4'd15;
	localparam logic [sca_pkg::DATA_W-1:0]   INT_MIN         = 32'h8000_0000;
	localparam logic [sca_pkg::DATA_W-1:0]   INT_MAX         = 32'h7fff_ffff;
	localparam logic [sca_pkg::DATA_W-1:0]   MINUS_ONE       = 32'hffff_ffff;

	// laid out as m_axis_tdata: top_value in the low bits
	typedef struct packed {
		logic [sca_pkg::STATUS_W-1:0]    status;
		logic [sca_pkg::DEPTH_OUT_W-1:0] stack_depth;
		logic signed [31:0]              top_value;
	} calc_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	logic [sca_pkg::S_TDATA_W-1:0] s_axis_tdata;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready;
	logic [sca_pkg::M_TDATA_W-1:0] m_axis_tdata;

	// stack model
	logic [sca_pkg::DATA_W-1:0] calc_stack [STACK_SLOTS];
	int                         calc_depth;

	calc_result_t expected_results [$];
	int           fail_count;
	int           beats_sent;
	int           tx_idle_pct;
	int           rx_stall_pct;
	int           hold_requests;

	stack_calculator_alu #(
		.STACK_DEPTH(STACK_SLOTS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// signed quotient, truncated toward zero; min / -1 wraps back to min
	function automatic logic [sca_pkg::DATA_W-1:0] quotient(
		input logic [sca_pkg::DATA_W-1:0] num,
		input logic [sca_pkg::DATA_W-1:0] den);
		longint q;
		q = longint'($signed(num)) / longint'($signed(den));
		return q[31:0];
	endfunction

	// floor square root by bitwise search over a 16-bit root
	function automatic logic [sca_pkg::DATA_W-1:0] floor_root(
		input logic [sca_pkg::DATA_W-1:0] v);
		logic [sca_pkg::DATA_W-1:0] root;
		logic [sca_pkg::DATA_W-1:0] trial;
		root = '0;
		for (int b = 15; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	// applies one opcode to the stack model and returns the result beat
	function automatic calc_result_t apply_opcode(input logic [sca_pkg::OPCODE_W-1:0] op,
	                                              input logic [sca_pkg::DATA_W-1:0] val);
		calc_result_t               res;
		logic [sca_pkg::DATA_W-1:0] t;
		logic [sca_pkg::DATA_W-1:0] s;
		logic [sca_pkg::DATA_W-1:0] r;
		logic                       ok;
		res.status = sca_pkg::ST_OK;
		if (op == sca_pkg::OP_PUSH) begin
			if (calc_depth >= STACK_SLOTS) begin
				res.status = sca_pkg::ST_OVER;
			end else begin
				calc_stack[calc_depth] = val;
				calc_depth++;
			end
		end else if (op == sca_pkg::OP_SQUARE || op == sca_pkg::OP_SQRT) begin
			if (calc_depth < 1) begin
				res.status = sca_pkg::ST_UNDER;
			end else begin
				t = calc_stack[calc_depth-1];
				if (op == sca_pkg::OP_SQUARE)
					calc_stack[calc_depth-1] = t * t;
				else if (t[31])
					res.status = sca_pkg::ST_NEGROOT;
				else
					calc_stack[calc_depth-1] = floor_root(t);
			end
		end else if (op <= sca_pkg::OP_RDIV) begin
			if (calc_depth < 2) begin
				res.status = sca_pkg::ST_UNDER;
			end else begin
				t  = calc_stack[calc_depth-1];
				s  = calc_stack[calc_depth-2];
				r  = '0;
				ok = 1'b1;
				case (op)
					sca_pkg::OP_ADD:   r = t + s;
					sca_pkg::OP_SUB:   r = t - s;
					sca_pkg::OP_MUL:   r = t * s;
					sca_pkg::OP_DIV:   if (s == '0) ok = 1'b0; else r = quotient(t, s);
					sca_pkg::OP_LINEQ: if (s == '0) ok = 1'b0; else r = quotient(32'd0 - t, s);
					sca_pkg::OP_RSUB:  r = s - t;
					default:           if (t == '0) ok = 1'b0; else r = quotient(s, t);
				endcase
				if (ok) begin
					calc_stack[calc_depth-2] = r;
					calc_depth--;
				end else begin
					res.status = sca_pkg::ST_DIVZ;
				end
			end
		end
		res.top_value   = (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
		res.stack_depth = calc_depth[sca_pkg::DEPTH_OUT_W-1:0];
		return res;
	endfunction

	function automatic logic [sca_pkg::DATA_W-1:0] rand_value();
		int pick;
		pick = $urandom_range(99);
		if (pick < 30)
			return $signed($urandom_range(40)) - 20;
		else if (pick < 45) begin
			case ($urandom_range(4))
				0:       return INT_MIN;
				1:       return INT_MAX;
				2:       return '0;
				3:       return MINUS_ONE;
				default: return 32'd1;
			endcase
		end else if (pick < 70)
			return $urandom_range(65535);
		return $urandom;
	endfunction

	function automatic logic [sca_pkg::OPCODE_W-1:0] rand_binary_op();
		case ($urandom_range(6))
			0:       return sca_pkg::OP_ADD;
			1:       return sca_pkg::OP_SUB;
			2:       return sca_pkg::OP_MUL;
			3:       return sca_pkg::OP_DIV;
			4:       return sca_pkg::OP_LINEQ;
			5:       return sca_pkg::OP_RSUB;
			default: return sca_pkg::OP_RDIV;
		endcase
	endfunction

	// Sends one beat and records its expected result. tvalid is only lowered
	// inside the idle loop, so back-to-back beats keep it high.
	task automatic send_beat(input logic [sca_pkg::OPCODE_W-1:0] op,
	                         input logic [sca_pkg::DATA_W-1:0] val);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{PAD_W{1'b0}}, val, op};
		do
			@(posedge clk);
		while (!s_axis_tready);
		expected_results.push_back(apply_opcode(op, val));
		beats_sent++;
	endtask

	task automatic set_idling(input int tx_pct, input int rx_pct);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
	endtask

	task automatic test_error_flags();
		send_beat(sca_pkg::OP_ADD, $urandom);
		send_beat(sca_pkg::OP_SQRT, $urandom);
		send_beat(sca_pkg::OP_SQUARE, $urandom);
		send_beat(sca_pkg::OP_PUSH, INT_MIN);
		send_beat(sca_pkg::OP_SUB, $urandom);      // one entry only
		send_beat(sca_pkg::OP_SQRT, $urandom);     // negative root
	endtask

	task automatic test_division_edges();
		send_beat(sca_pkg::OP_PUSH, MINUS_ONE);
		send_beat(sca_pkg::OP_RDIV, $urandom);     // min / -1 wraps
		send_beat(sca_pkg::OP_PUSH, '0);
		send_beat(sca_pkg::OP_PUSH, 32'd7);
		send_beat(sca_pkg::OP_DIV, $urandom);      // zero divisor
		send_beat(sca_pkg::OP_LINEQ, $urandom);    // zero divisor
		send_beat(sca_pkg::OP_RDIV, $urandom);
		send_beat(sca_pkg::OP_PUSH, MINUS_ONE);
		send_beat(sca_pkg::OP_PUSH, INT_MIN);
		send_beat(sca_pkg::OP_LINEQ, $urandom);    // negating min wraps
	endtask

	task automatic test_root_and_square();
		send_beat(sca_pkg::OP_PUSH, INT_MAX);
		send_beat(sca_pkg::OP_SQRT, $urandom);
		send_beat(sca_pkg::OP_SQUARE, $urandom);
		send_beat(sca_pkg::OP_PUSH, INT_MIN);
		send_beat(sca_pkg::OP_MUL, $urandom);
		send_beat(sca_pkg::OP_RSUB, $urandom);
		send_beat(sca_pkg::OP_ADD, $urandom);
	endtask

	task automatic test_unused_codes();
		send_beat(OP_FIRST_UNUSED, $urandom);
		send_beat(OP_LAST_UNUSED, $urandom);
	endtask

	task automatic test_full_stack();
		while (calc_depth < STACK_SLOTS)
			send_beat(sca_pkg::OP_PUSH, rand_value());
		send_beat(sca_pkg::OP_PUSH, INT_MAX);      // overflow
		send_beat(sca_pkg::OP_SUB, $urandom);
		send_beat(sca_pkg::OP_DIV, $urandom);
	endtask

	// Mostly well-formed sequences: pushes then ops that have operands,
	// with occasional fills to overflow and some noise.
	task automatic run_random(input int count);
		int                           stop_at;
		int                           pick;
		logic [sca_pkg::OPCODE_W-1:0] op;
		stop_at = beats_sent + count;
		while (beats_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 2) begin
				while (calc_depth < STACK_SLOTS)
					send_beat(sca_pkg::OP_PUSH, rand_value());
				repeat ($urandom_range(2, 1)) send_beat(sca_pkg::OP_PUSH, $urandom);
			end else if (pick < 6) begin
				op = sca_pkg::OPCODE_W'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
				send_beat(op, $urandom);
			end else if (pick < 42 || (calc_depth < 2 && pick < 75)) begin
				send_beat(sca_pkg::OP_PUSH, rand_value());
			end else if (pick < 84) begin
				send_beat(rand_binary_op(), $urandom);
			end else begin
				send_beat(($urandom_range(1) != 0) ? sca_pkg::OP_SQRT : sca_pkg::OP_SQUARE,
				          $urandom);
			end
		end
	endtask

	// receiver holds off while beats keep coming, so the input side stalls
	task automatic test_input_backpressure();
		set_idling(0, 0);
		hold_requests++;
		run_random(12);
	endtask

	// result sink: random stalls plus the requested long hold-off
	initial begin
		int hold_left;
		int served;
		hold_left     = 0;
		served        = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != served) begin
				served    = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// result check and watchdog
	initial begin
		calc_result_t got;
		calc_result_t want;
		int           quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (m_axis_tvalid && m_axis_tready) begin
					got = calc_result_t'(m_axis_tdata);
					if (expected_results.size() == 0) begin
						$error("unexpected result beat: top_value %0d", got.top_value);
						fail_count++;
					end else begin
						want = expected_results.pop_front();
						if (got.top_value !== want.top_value) begin
							$error("top_value: expected %0d, got %0d",
							       want.top_value, got.top_value);
							fail_count++;
						end
						if (got.stack_depth !== want.stack_depth) begin
							$error("stack_depth: expected %0d, got %0d",
							       want.stack_depth, got.stack_depth);
							fail_count++;
						end
						if (got.status !== want.status) begin
							$error("status: expected %0d, got %0d", want.status, got.status);
							fail_count++;
						end
					end
				end
				if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
					quiet = 0;
				else
					quiet++;
				if (quiet >= WATCHDOG_LIMIT) begin
					$display("FAIL stack_calculator_alu");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		tx_idle_pct   = 0;
		rx_stall_pct  = 0;
		hold_requests = 0;
		calc_depth    = 0;
		fail_count    = 0;
		beats_sent    = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		set_idling(0, 0);
		test_error_flags();
		test_division_edges();
		test_root_and_square();
		test_unused_codes();
		test_full_stack();

		set_idling(0, 0);
		run_random(300);
		set_idling(48, 0);
		run_random(300);
		test_input_backpressure();
		set_idling(0, 48);
		run_random(300);
		set_idling(8, 8);
		run_random(300);

		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS stack_calculator_alu");
		else
			$display("FAIL stack_calculator_alu");
		$finish;
	end

endmodule

[sim.f]
src/sca_pkg.sv
src/sca_ram.sv
src/stack_calculator_alu.sv
bench/tb_stack_calculator_alu.sv
